@@ hdl/qks_pkg.sv @@
// qks_pkg: shared types and constants of the quadrature knob speed setting block
package qks_pkg;

  // item kinds
  typedef enum logic {
    OP_PINS   = 1'b0,
    OP_BUTTON = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FAST_WINDOW = 2'd0,
    CFG_FAST_STEP   = 2'd1,
    CFG_DUTY_FLOOR  = 2'd2
  } cfg_reg_t;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // configuration reset values
  localparam logic [31:0] FAST_WINDOW_RESET = 32'd25000;
  localparam logic [7:0]  FAST_STEP_RESET   = 8'd10;
  localparam logic [7:0]  DUTY_FLOOR_RESET  = 8'd55;

  // speed limits and duty full scale
  localparam logic [7:0] SPEED_MIN   = 8'd40;
  localparam logic [7:0] SPEED_MAX   = 8'd200;
  localparam logic [7:0] SPEED_RESET = 8'd100;
  localparam logic [7:0] DUTY_MAX    = 8'd255;

  // sub-step count limit per detent
  localparam logic signed [3:0] SUBSTEP_LIMIT = 4'sd3;

  // idle level of both encoder pins
  localparam logic [1:0] PINS_RESET = 2'b11;

  // reciprocal of 5 for the speed span of 160 = 32 * 5
  localparam logic [15:0] RECIP5       = 16'd52429;
  localparam int          RECIP5_SHIFT = 18;

  // quadrature transition table, index {previous pins, current pins}
  localparam logic signed [1:0] QUAD_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  // knob control state
  typedef struct packed {
    logic              unlock;
    logic              held;
    logic [1:0]        prev_pins;
    logic signed [3:0] substep;
    logic [7:0]        speed;
  } knob_state_t;

  // detent taken by one sample
  typedef struct packed {
    logic up;
    logic down;
  } detent_t;

endpackage

@@ hdl/quadrature_knob_speed_setting.sv @@
// quadrature_knob_speed_setting: rotary knob speed setting with lock and acceleration
//
// Input channel (in_valid/in_ready) carries one sample per transaction: op selects
// an encoder pin sample (pin_a, pin_b) or a button sample (button_down); time_us
// is the sample's microsecond timestamp. Every input transaction yields exactly
// one output transaction (out_valid/out_ready) with speed_setting, fan_duty and
// unlocked after that sample.
// The block is a three-register pipeline: input register, state update into a
// stage register that also holds the speed-times-slope product, then the output
// register where the product is divided by 160 with a reciprocal multiply.
// One transaction per cycle is sustained while out_ready stays high; the knob state
// update is combinational and is committed as each sample leaves the input register.
// A stalled receiver holds the output register; the stages behind it keep
// filling, and in_ready drops once all three are full.
// Synchronous reset empties the pipeline, locks the knob, sets speed to 100 and
// loads the configuration defaults (window 25000 us, fast step 10, duty floor 55).
// The cfg port writes fast_window_us, fast_step, duty_floor at indexes 0..2.
module quadrature_knob_speed_setting #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [qks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qks_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic                           pin_a,
  input  logic                           pin_b,
  input  logic                           button_down,
  input  logic [31:0]                    time_us,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     speed_setting,
  output logic [7:0]                     fan_duty,
  output logic                           unlocked
);

  localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  // configuration registers
  logic [31:0] fast_window_us;
  logic [7:0]  fast_step;
  logic [7:0]  duty_floor;

  // knob state
  qks_pkg::knob_state_t  state;
  qks_pkg::knob_state_t  state_next;
  qks_pkg::detent_t      detent;
  logic [TIME_WIDTH-1:0] last_up_time;
  logic [TIME_WIDTH-1:0] last_down_time;

  // input register
  logic        v0;
  logic        op0;
  logic        a0;
  logic        b0;
  logic        btn0;
  logic [31:0] time0;

  // middle stage
  logic        v1;
  logic [7:0]  speed1;
  logic        unlock1;
  logic [15:0] prod1;

  logic                  adv0;
  logic                  adv1;
  logic                  rdy1;
  logic [CMP_W-1:0]      time_ext;
  logic [TIME_WIDTH-1:0] now;
  logic [7:0]            speed_off;
  logic [7:0]            slope;
  logic [15:0]           prod_next;
  logic [10:0]           prod_div32;
  logic [26:0]           recip_prod;
  logic [7:0]            duty_quot;

  // pipeline flow control
  assign adv1     = v1 && (!out_valid || out_ready);
  assign rdy1     = !v1 || adv1;
  assign adv0     = v0 && rdy1;
  assign in_ready = !v0 || adv0;

  // timestamp taken modulo 2^TIME_WIDTH
  assign time_ext = CMP_W'(time0);
  assign now      = time_ext[TIME_WIDTH-1:0];

  qks_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .state          (state),
    .op             (op0),
    .pin_a          (a0),
    .pin_b          (b0),
    .button_down    (btn0),
    .now            (now),
    .last_up_time   (last_up_time),
    .last_down_time (last_down_time),
    .fast_window_us (fast_window_us),
    .fast_step      (fast_step),
    .state_next     (state_next),
    .detent         (detent)
  );

  // duty numerator: (speed - min) * (full scale - floor)
  assign speed_off = state_next.speed - qks_pkg::SPEED_MIN;
  assign slope     = qks_pkg::DUTY_MAX - duty_floor;
  assign prod_next = 16'(speed_off) * 16'(slope);

  // divide by 160: shift by 5, then multiply by the reciprocal of 5
  assign prod_div32 = prod1[15:5];
  assign recip_prod = 27'(prod_div32) * 27'(qks_pkg::RECIP5);
  assign duty_quot  = recip_prod[qks_pkg::RECIP5_SHIFT +: 8];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_window_us <= qks_pkg::FAST_WINDOW_RESET;
      fast_step      <= qks_pkg::FAST_STEP_RESET;
      duty_floor     <= qks_pkg::DUTY_FLOOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        qks_pkg::CFG_FAST_WINDOW: fast_window_us <= cfg_data;
        qks_pkg::CFG_FAST_STEP:   fast_step      <= cfg_data[7:0];
        qks_pkg::CFG_DUTY_FLOOR:  duty_floor     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // knob state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state.unlock    <= 1'b0;
      state.held      <= 1'b0;
      state.prev_pins <= qks_pkg::PINS_RESET;
      state.substep   <= 4'sd0;
      state.speed     <= qks_pkg::SPEED_RESET;
      last_up_time    <= '0;
      last_down_time  <= '0;
    end else if (adv0) begin
      state <= state_next;
      if (detent.up) begin
        last_up_time <= now;
      end
      if (detent.down) begin
        last_down_time <= now;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v0 <= in_valid;
      end
      if (rdy1) begin
        v1 <= adv0;
      end
      if (!out_valid || out_ready) begin
        out_valid <= adv1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op0   <= op;
      a0    <= pin_a;
      b0    <= pin_b;
      btn0  <= button_down;
      time0 <= time_us;
    end
    if (adv0) begin
      speed1  <= state_next.speed;
      unlock1 <= state_next.unlock;
      prod1   <= prod_next;
    end
    if (adv1) begin
      speed_setting <= speed1;
      unlocked      <= unlock1;
      fan_duty      <= duty_floor + duty_quot;
    end
  end

`ifndef SYNTHESIS
  // speed register stays inside the clamp range
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    state.speed >= qks_pkg::SPEED_MIN && state.speed <= qks_pkg::SPEED_MAX)
    else $error("speed state out of range");

  // sub-step count stays within one detent between samples
  a_substep_range: assert property (@(posedge clk) disable iff (rst)
    state.substep <= qks_pkg::SUBSTEP_LIMIT && state.substep >= -qks_pkg::SUBSTEP_LIMIT)
    else $error("sub-step count out of range");

  // a pin sample on a locked knob leaves the knob state alone
  a_locked_ignores: assert property (@(posedge clk) disable iff (rst)
    adv0 && op0 == qks_pkg::OP_PINS && !state.unlock |=>
      $stable(state.prev_pins) && $stable(state.speed) && $stable(state.substep))
    else $error("locked knob changed state");
`endif

endmodule

@@ hdl/qks_step.sv @@
// qks_step: next-state logic for one knob or button sample
module qks_step #(
  parameter int TIME_WIDTH = 32
) (
  input  qks_pkg::knob_state_t  state,
  input  logic                  op,
  input  logic                  pin_a,
  input  logic                  pin_b,
  input  logic                  button_down,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [TIME_WIDTH-1:0] last_up_time,
  input  logic [TIME_WIDTH-1:0] last_down_time,
  input  logic [31:0]           fast_window_us,
  input  logic [7:0]            fast_step,
  output qks_pkg::knob_state_t  state_next,
  output qks_pkg::detent_t      detent
);

  localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  logic [1:0]            cur_pins;
  logic [3:0]            tbl_idx;
  logic signed [1:0]     tbl_val;
  logic signed [3:0]     substep_sum;
  logic [TIME_WIDTH-1:0] last_time;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  fast;
  logic [7:0]            step;
  logic signed [9:0]     speed_sum;
  logic [7:0]            speed_clamped;

  // quadrature decode
  assign cur_pins    = {pin_a, pin_b};
  assign tbl_idx     = {state.prev_pins, cur_pins};
  assign tbl_val     = qks_pkg::QUAD_TABLE[tbl_idx];
  assign substep_sum = state.substep + {{2{tbl_val[1]}}, tbl_val};

  // acceleration: same direction within the window
  always_comb begin
    last_time = detent.up ? last_up_time : last_down_time;
    elapsed   = now - last_time;
    fast      = CMP_W'(elapsed) < CMP_W'(fast_window_us);
    step      = fast ? fast_step : 8'd1;
    if (detent.up) begin
      speed_sum = $signed({2'b00, state.speed}) + $signed({2'b00, step});
    end else begin
      speed_sum = $signed({2'b00, state.speed}) - $signed({2'b00, step});
    end
    if (speed_sum < $signed({2'b00, qks_pkg::SPEED_MIN})) begin
      speed_clamped = qks_pkg::SPEED_MIN;
    end else if (speed_sum > $signed({2'b00, qks_pkg::SPEED_MAX})) begin
      speed_clamped = qks_pkg::SPEED_MAX;
    end else begin
      speed_clamped = speed_sum[7:0];
    end
  end

  // state update
  always_comb begin
    state_next  = state;
    detent.up   = 1'b0;
    detent.down = 1'b0;
    if (op == qks_pkg::OP_BUTTON) begin
      if (button_down && !state.held) begin
        state_next.held   = 1'b1;
        state_next.unlock = !state.unlock;
      end else if (!button_down) begin
        state_next.held = 1'b0;
      end
    end else if (state.unlock) begin
      state_next.prev_pins = cur_pins;
      if (substep_sum > qks_pkg::SUBSTEP_LIMIT) begin
        detent.up          = 1'b1;
        state_next.substep = 4'sd0;
      end else if (substep_sum < -qks_pkg::SUBSTEP_LIMIT) begin
        detent.down        = 1'b1;
        state_next.substep = 4'sd0;
      end else begin
        state_next.substep = substep_sum;
      end
    end
    if (detent.up || detent.down) begin
      state_next.speed = speed_clamped;
    end
  end

endmodule
